// ===== hdl/stq_pkg.sv =====
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int ID_W        = 16;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] wake_time;
        logic [ID_W-1:0]   proc_id;
    } slot_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic              insert_en;
        logic              pop_en;
        logic              remove_en;
        logic [TIME_W-1:0] key_time;
        logic [ID_W-1:0]   key_id;
    } cell_ctl_t;

    // passed from a cell to its right neighbor
    typedef struct packed {
        slot_t slot;
        logic  lt;
        logic  found;
    } cell_link_t;

endpackage

// ===== hdl/stq_if.sv =====
interface stq_req_if
    import stq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    op_t                  opcode;
    logic [TIME_W-1:0]    wake_time;
    logic [ID_W-1:0]      proc_id;

    modport source (output valid, output opcode, output wake_time, output proc_id,
                    input ready);
    modport sink   (input valid, input opcode, input wake_time, input proc_id,
                    output ready);
endinterface

interface stq_rsp_if
    import stq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [ID_W-1:0]      taken_id;
    logic [TIME_W-1:0]    taken_time;
    logic [POS_W-1:0]     position;
    logic [TIME_W-1:0]    head_time;
    logic [ID_W-1:0]      head_id;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;

    modport source (output valid, output status, output taken_id, output taken_time,
                    output position, output head_time, output head_id,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input taken_id, input taken_time,
                    input position, input head_time, input head_id,
                    input entry_count, input is_empty, output ready);
endinterface

// ===== hdl/sorted_timer_queue.sv =====
// Sorted timer queue: up to QUEUE_DEPTH wake-up entries kept in order of
// wake time, head first, in a row of slot cells that shift toward or away
// from the head.
// req channel carries opcode, wake_time and proc_id: insert, pop head,
// remove by id, find position by id. rsp channel returns one result per
// request: status, the entry taken, the found position, and the head,
// count and empty flag after the operation.
// Each request is applied to all cells in the cycle it is accepted; its
// result is captured in the output register. One request per cycle is
// sustained while the receiver keeps ready high; the rate is set by the
// single output register. When the receiver stalls, the result holds and
// no new request is taken until it is accepted. Equal wake times leave in
// reverse arrival order. Reset empties the queue (slot valid bits cleared)
// and drops any pending result; slot contents are not cleared.
module sorted_timer_queue
    import stq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    stq_req_if.sink   req_ch,
    stq_rsp_if.source rsp_ch
);

    cell_ctl_t  ctl;
    cell_link_t link [QUEUE_DEPTH+1];
    slot_t      back [QUEUE_DEPTH+1];
    slot_t      slot_cur [QUEUE_DEPTH];
    slot_t      slot_nxt [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] first_hit;
    logic [QUEUE_DEPTH-1:0] valid_vec;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;
    logic             full;
    logic             any_hit;
    logic [IDX_W-1:0] hit_idx;
    slot_t            hit_slot;

    logic               rsp_valid_reg;
    status_t            status_reg;
    status_t            status_next;
    logic [ID_W-1:0]    taken_id_reg;
    logic [ID_W-1:0]    taken_id_next;
    logic [TIME_W-1:0]  taken_time_reg;
    logic [TIME_W-1:0]  taken_time_next;
    logic [POS_W-1:0]   position_reg;
    logic [POS_W-1:0]   position_next;
    logic [TIME_W-1:0]  head_time_reg;
    logic [ID_W-1:0]    head_id_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               empty_reg;

    assign req_ch.ready = !rsp_valid_reg || rsp_ch.ready;
    assign accept       = req_ch.valid && req_ch.ready;
    assign full         = (cnt_reg == CNT_W'(QUEUE_DEPTH));

    assign ctl.insert_en = accept && (req_ch.opcode == OP_INSERT) && !full;
    assign ctl.pop_en    = accept && (req_ch.opcode == OP_POP) && (cnt_reg != '0);
    assign ctl.remove_en = accept && (req_ch.opcode == OP_REMOVE);
    assign ctl.key_time  = req_ch.wake_time;
    assign ctl.key_id    = req_ch.proc_id;

    assign link[0].slot  = '0;
    assign link[0].lt    = 1'b1;
    assign link[0].found = 1'b0;
    assign back[QUEUE_DEPTH] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        stq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .left       (link[i]),
            .right_slot (back[i+1]),
            .link       (link[i+1]),
            .slot       (slot_cur[i]),
            .slot_next  (slot_nxt[i]),
            .first_hit  (first_hit[i])
        );
        assign back[i]      = slot_cur[i];
        assign valid_vec[i] = slot_cur[i].valid;
    end

    assign any_hit = link[QUEUE_DEPTH].found;

    always_comb
    begin
        hit_idx  = '0;
        hit_slot = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (first_hit[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_slot = hit_slot | slot_cur[i];
            end
        end
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        status_next     = ST_OK;
        taken_id_next   = '0;
        taken_time_next = '0;
        position_next   = '0;
        unique case (req_ch.opcode)
            OP_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_POP:
            begin
                if (cnt_reg == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    cnt_next        = cnt_reg - CNT_W'(1);
                    taken_id_next   = slot_cur[0].proc_id;
                    taken_time_next = slot_cur[0].wake_time;
                end
            end
            OP_REMOVE:
            begin
                if (!any_hit)
                    status_next = ST_NOTFOUND;
                else
                begin
                    cnt_next        = cnt_reg - CNT_W'(1);
                    taken_id_next   = hit_slot.proc_id;
                    taken_time_next = hit_slot.wake_time;
                end
            end
            OP_FIND:
            begin
                if (!any_hit)
                    status_next = ST_NOTFOUND;
                else
                    position_next = POS_W'(hit_idx);
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                cnt_reg <= cnt_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ch.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            taken_id_reg   <= taken_id_next;
            taken_time_reg <= taken_time_next;
            position_reg   <= position_next;
            head_time_reg  <= (cnt_next == '0) ? '0 : slot_nxt[0].wake_time;
            head_id_reg    <= (cnt_next == '0) ? '0 : slot_nxt[0].proc_id;
            count_reg      <= COUNT_W'(cnt_next);
            empty_reg      <= (cnt_next == '0);
        end
    end

    assign rsp_ch.valid       = rsp_valid_reg;
    assign rsp_ch.status      = status_reg;
    assign rsp_ch.taken_id    = taken_id_reg;
    assign rsp_ch.taken_time  = taken_time_reg;
    assign rsp_ch.position    = position_reg;
    assign rsp_ch.head_time   = head_time_reg;
    assign rsp_ch.head_id     = head_id_reg;
    assign rsp_ch.entry_count = count_reg;
    assign rsp_ch.is_empty    = empty_reg;

    // the number of occupied slots always equals the count (they form a prefix)
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(cnt_reg))
        else $error("slot count mismatch");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("count above depth");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_hit))
        else $error("more than one first match");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop_en |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("pop did not shrink queue");

    a_full_rejects: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && req_ch.opcode == OP_INSERT) |=> $stable(valid_vec))
        else $error("insert changed a full queue");

endmodule

// ===== hdl/stq_cell.sv =====
module stq_cell
    import stq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  cell_link_t left,
    input  slot_t      right_slot,
    output cell_link_t link,
    output slot_t      slot,
    output slot_t      slot_next,
    output logic       first_hit
);

    logic  valid_reg;
    logic  valid_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic  lt_self;
    logic  hit_self;
    logic  found_upto;

    assign lt_self    = valid_reg && (time_reg < ctl.key_time);
    assign hit_self   = valid_reg && (id_reg == ctl.key_id);
    assign found_upto = left.found || hit_self;
    assign first_hit  = hit_self && !left.found;

    always_comb
    begin
        valid_next = valid_reg;
        time_next  = time_reg;
        id_next    = id_reg;
        if (ctl.insert_en)
        begin
            if (!lt_self)
            begin
                if (left.lt)
                begin
                    valid_next = 1'b1;
                    time_next  = ctl.key_time;
                    id_next    = ctl.key_id;
                end
                else
                begin
                    valid_next = left.slot.valid;
                    time_next  = left.slot.wake_time;
                    id_next    = left.slot.proc_id;
                end
            end
        end
        else if (ctl.pop_en || (ctl.remove_en && found_upto))
        begin
            valid_next = right_slot.valid;
            time_next  = right_slot.wake_time;
            id_next    = right_slot.proc_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign slot       = '{valid: valid_reg, wake_time: time_reg, proc_id: id_reg};
    assign slot_next  = '{valid: valid_next, wake_time: time_next, proc_id: id_next};
    assign link.slot  = slot;
    assign link.lt    = lt_self;
    assign link.found = found_upto;

endmodule
